FILE: sv/fba_pkg.sv
// Package for the fit block allocator: item payload types and named codes.
// Used by the channel interfaces and by the allocator top level.
// Depends on nothing.
package fba_pkg;

  // Request type codes carried in the req_type field.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  // Placement policy codes held in the fit_mode register.
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // Configuration port layout.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 2'd1;

  // Register reset values.
  localparam logic [1:0] FIT_MODE_RESET      = FIT_FIRST;
  localparam logic [4:0] BLOCKS_IN_USE_RESET = 5'd16;

  // Fixed field widths of the item payloads.
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned VAL_W  = 16;

  // One input item.
  typedef struct packed {
    logic             req_type;
    logic [SLOT_W-1:0] block_slot;
    logic [VAL_W-1:0]  size_value;
  } req_t;

  // One result item.
  typedef struct packed {
    logic             granted;
    logic [SLOT_W-1:0] block_index;
    logic [VAL_W-1:0]  remaining_size;
  } rsp_t;

endpackage

FILE: sv/fba_req_if.sv
// Request channel of the fit block allocator: valid, ready and one item.
// Depends on fba_pkg.
interface fba_req_if;
  logic          valid;
  logic          ready;
  fba_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/fba_rsp_if.sv
// Result channel of the fit block allocator: valid, ready and one item.
// Depends on fba_pkg.
interface fba_rsp_if;
  logic          valid;
  logic          ready;
  fba_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/fit_block_allocator.sv
// Timing: a load item gives its result in the cycle after it is accepted; an allocate
// item scans n entries in ST_SCAN, then passes ST_UPDATE and ST_DONE, n being the saturated
// block count (zero goes straight to ST_DONE). Items are taken one at a time, the next only
// after the result is taken; the single table read port and comparator visit one entry a cycle.
// Reset: asynchronous, active low; control registers return to their reset values and per-entry
// valid bits clear at once, so every table entry reads as zero with no clearing pass.
module fit_block_allocator #(
  parameter int unsigned NUM_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fba_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fba_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  fba_req_if.sink                          req,
  fba_rsp_if.source                        rsp
);

  localparam int unsigned IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned CMP_W = (SIZE_BITS > fba_pkg::VAL_W) ? SIZE_BITS : fba_pkg::VAL_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_DONE   = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [1:0]           mode_q;
  logic [4:0]           biu_q;
  logic [CMP_W-1:0]     req_size_q, req_size_d;
  logic [CNT_W-1:0]     n_q, n_d;
  logic [IDX_W-1:0]     ptr_q, ptr_d;
  logic                 issue_q, issue_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]     rd_idx_q;
  logic [SIZE_BITS-1:0] rd_data_q;
  logic                 rd_ok_q;
  logic                 found_q, found_d;
  logic [IDX_W-1:0]     pick_idx_q, pick_idx_d;
  logic [SIZE_BITS-1:0] pick_val_q, pick_val_d;
  fba_pkg::rsp_t        rsp_q, rsp_d;

  logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] vld_q;

  logic                 req_fire, rsp_fire;
  logic                 slot_ok;
  logic [SIZE_BITS-1:0] load_val;
  logic [CNT_W-1:0]     n_sat;
  logic [SIZE_BITS-1:0] cur_val;
  logic                 fits, better, take;
  logic [SIZE_BITS-1:0] new_val;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [SIZE_BITS-1:0] mem_wdata;

  assign req_fire = req.valid && req.ready;
  assign rsp_fire = rsp.valid && rsp.ready;
  assign req.ready = (state_q == ST_IDLE);
  assign rsp.valid = (state_q == ST_DONE);
  assign rsp.data  = rsp_q;

  // Load decode and the saturated number of entries to search.
  assign slot_ok  = int'(req.data.block_slot) < NUM_BLOCKS;
  assign load_val = SIZE_BITS'(req.data.size_value);
  assign n_sat    = (int'(biu_q) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : CNT_W'(biu_q);

  // Shared compare unit: fit test and policy test on the entry just read.
  assign cur_val = rd_ok_q ? rd_data_q : '0;
  assign fits    = req_size_q <= CMP_W'(cur_val);
  assign better  = ((mode_q == fba_pkg::FIT_BEST)  && (cur_val < pick_val_q)) ||
                   ((mode_q == fba_pkg::FIT_WORST) && (cur_val > pick_val_q));
  assign take    = rd_vld_q && fits && (!found_q || better);
  assign new_val = pick_val_q - SIZE_BITS'(req_size_q);

  // Table write port: a load in idle or the subtraction after a search.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pick_idx_q;
    mem_wdata = new_val;
    if ((state_q == ST_IDLE) && req_fire && (req.data.req_type == fba_pkg::REQ_LOAD)
        && slot_ok) begin
      mem_we    = 1'b1;
      mem_waddr = IDX_W'(req.data.block_slot);
      mem_wdata = load_val;
    end else if ((state_q == ST_UPDATE) && found_q) begin
      mem_we = 1'b1;
    end
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    req_size_d = req_size_q;
    n_d        = n_q;
    ptr_d      = ptr_q;
    issue_d    = issue_q;
    rd_vld_d   = 1'b0;
    found_d    = found_q;
    pick_idx_d = pick_idx_q;
    pick_val_d = pick_val_q;
    rsp_d      = rsp_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          if (req.data.req_type == fba_pkg::REQ_LOAD) begin
            rsp_d.granted        = slot_ok;
            rsp_d.block_index    = slot_ok ? req.data.block_slot : '0;
            rsp_d.remaining_size = slot_ok ? fba_pkg::VAL_W'(load_val) : '0;
            state_d              = ST_DONE;
          end else begin
            req_size_d = CMP_W'(req.data.size_value);
            n_d        = n_sat;
            ptr_d      = '0;
            found_d    = 1'b0;
            pick_idx_d = '0;
            pick_val_d = '0;
            if (n_sat == '0) begin
              rsp_d   = '0;
              state_d = ST_DONE;
            end else begin
              issue_d = 1'b1;
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        // Read one entry a cycle; compare it the cycle after.
        if (issue_q) begin
          ptr_d    = ptr_q + IDX_W'(1);
          rd_vld_d = 1'b1;
          if (CNT_W'(ptr_q) == n_q - CNT_W'(1)) begin
            issue_d = 1'b0;
          end
        end
        if (take) begin
          found_d    = 1'b1;
          pick_idx_d = rd_idx_q;
          pick_val_d = cur_val;
        end
        if (rd_vld_q && (CNT_W'(rd_idx_q) == n_q - CNT_W'(1))) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (found_q) begin
          rsp_d.granted        = 1'b1;
          rsp_d.block_index    = fba_pkg::SLOT_W'(pick_idx_q);
          rsp_d.remaining_size = fba_pkg::VAL_W'(new_val);
        end else begin
          rsp_d = '0;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (rsp_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mode_q   <= fba_pkg::FIT_MODE_RESET;
      biu_q    <= fba_pkg::BLOCKS_IN_USE_RESET;
      issue_q  <= 1'b0;
      rd_vld_q <= 1'b0;
      rd_ok_q  <= 1'b0;
      found_q  <= 1'b0;
      vld_q    <= '0;
    end else begin
      state_q  <= state_d;
      issue_q  <= issue_d;
      rd_vld_q <= rd_vld_d;
      rd_ok_q  <= vld_q[ptr_q];
      found_q  <= found_d;
      if (mem_we) begin
        vld_q[mem_waddr] <= 1'b1;
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == fba_pkg::REG_FIT_MODE) begin
          mode_q <= cfg_wdata_i[1:0];
        end else if (cfg_idx_i == fba_pkg::REG_BLOCKS_IN_USE) begin
          biu_q <= cfg_wdata_i;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_size_q <= req_size_d;
    n_q        <= n_d;
    ptr_q      <= ptr_d;
    pick_idx_q <= pick_idx_d;
    pick_val_q <= pick_val_d;
    rsp_q      <= rsp_d;
  end

  // Block size table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[ptr_q];
    rd_idx_q  <= ptr_q;
  end

endmodule

FILE: sv/fba_checker.sv
// Port-level checker for the fit block allocator, with its bind statement.
// Sees only the top level's channel and reset signals; depends on nothing else.
module fba_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic        rsp_granted_i,
  input logic [3:0]  rsp_block_index_i,
  input logic [15:0] rsp_remaining_size_i
);

  // A refused item reports a zero index and a zero size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_granted_i) |-> (rsp_block_index_i == 4'd0 &&
                                         rsp_remaining_size_i == 16'd0))
    else $error("refused item carries a nonzero index or size");

  // One item at a time: the block stops taking items right after it takes one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("second item taken while one is in work");

  // No new item is taken while a result is still pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !req_ready_i)
    else $error("item taken while a result waits");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(rsp_granted_i) &&
      $stable(rsp_block_index_i) && $stable(rsp_remaining_size_i)))
    else $error("stalled result changed");

endmodule

bind fit_block_allocator fba_checker u_fba_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .req_valid_i          (req.valid),
  .req_ready_i          (req.ready),
  .rsp_valid_i          (rsp.valid),
  .rsp_ready_i          (rsp.ready),
  .rsp_granted_i        (rsp.data.granted),
  .rsp_block_index_i    (rsp.data.block_index),
  .rsp_remaining_size_i (rsp.data.remaining_size)
);

FILE: sim/tb_fit_block_allocator.sv
`timescale 1ns / 1ps
// Self-checking testbench for fit_block_allocator: predicts every result item
// from its own copy of the size table and fit settings. Depends on fba_pkg,
// fba_req_if, fba_rsp_if and the allocator top level.
module tb_fit_block_allocator;

  localparam int unsigned BLOCKS = 16;
  localparam logic [1:0]  FIT_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 24;

  // Tracks the expected size table and queues the result each request should give.
  class alloc_tracker;
    logic [fba_pkg::VAL_W-1:0] sizes[BLOCKS];
    logic [1:0]                mode;
    logic [4:0]                used;
    fba_pkg::rsp_t             expected_grants[$];
    int unsigned               faults, loads, grants, refusals;

    function new();
      foreach (sizes[j]) sizes[j] = '0;
      mode = fba_pkg::FIT_MODE_RESET;
      used = fba_pkg::BLOCKS_IN_USE_RESET;
    endfunction

    function void set_reg(logic [fba_pkg::CFG_IDX_W-1:0] idx,
                          logic [fba_pkg::CFG_DATA_W-1:0] val);
      if (idx == fba_pkg::REG_FIT_MODE) mode = val[1:0];
      else if (idx == fba_pkg::REG_BLOCKS_IN_USE) used = val;
    endfunction

    // Apply one request to the table and return the result it produces.
    function fba_pkg::rsp_t predict_grant(fba_pkg::req_t r);
      fba_pkg::rsp_t o;
      int unsigned   n;
      int unsigned   pick;
      bit            found;
      o = '0;
      pick = 0;
      found = 1'b0;
      if (r.req_type == fba_pkg::REQ_LOAD) begin
        sizes[r.block_slot] = r.size_value;
        o.granted = 1'b1;
        o.block_index = r.block_slot;
        o.remaining_size = r.size_value;
        return o;
      end
      n = (used > BLOCKS) ? BLOCKS : used;
      for (int unsigned j = 0; j < n; j++) begin
        if (r.size_value > sizes[j]) continue;
        if (!found) begin
          found = 1'b1;
          pick = j;
          if (mode != fba_pkg::FIT_BEST && mode != fba_pkg::FIT_WORST) break;
        end else if (mode == fba_pkg::FIT_BEST) begin
          if (sizes[j] < sizes[pick]) pick = j;
        end else if (mode == fba_pkg::FIT_WORST) begin
          if (sizes[j] > sizes[pick]) pick = j;
        end
      end
      if (found) begin
        sizes[pick] = sizes[pick] - r.size_value;
        o.granted = 1'b1;
        o.block_index = pick[fba_pkg::SLOT_W-1:0];
        o.remaining_size = sizes[pick];
      end
      return o;
    endfunction

    function void note_request(fba_pkg::req_t r);
      fba_pkg::rsp_t want;
      want = predict_grant(r);
      if (r.req_type == fba_pkg::REQ_LOAD) loads++;
      else if (want.granted) grants++;
      else refusals++;
      expected_grants.push_back(want);
    endfunction

    function void report_fault(string what, fba_pkg::rsp_t want, fba_pkg::rsp_t got);
      faults++;
      if (faults <= 10)
        $display("[%0t] %s: expected g=%0b idx=%0d rem=%0d, got g=%0b idx=%0d rem=%0d",
                 $time, what, want.granted, want.block_index, want.remaining_size,
                 got.granted, got.block_index, got.remaining_size);
    endfunction

    function void check_result(fba_pkg::rsp_t got);
      fba_pkg::rsp_t want;
      if (expected_grants.size() == 0) begin
        report_fault("result with nothing outstanding", '0, got);
        return;
      end
      want = expected_grants.pop_front();
      if (got.granted !== want.granted) report_fault("granted differs", want, got);
      else if (got.block_index !== want.block_index)
        report_fault("block_index differs", want, got);
      else if (got.remaining_size !== want.remaining_size)
        report_fault("remaining_size differs", want, got);
    endfunction

    function int unsigned pending();
      return expected_grants.size();
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [fba_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [fba_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  fba_req_if req_if();
  fba_rsp_if rsp_if();

  alloc_tracker tracker = new();

  int unsigned send_idle_pct = 31;
  bit          rsp_calm = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned settings_seen = 0;

  fit_block_allocator #(
    .NUM_BLOCKS(BLOCKS),
    .SIZE_BITS (fba_pkg::VAL_W)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req        (req_if),
    .rsp        (rsp_if)
  );

  // Free-running 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Result side: check each accepted item, then pick the next ready value.
  initial begin : rsp_side
    int unsigned hold_left;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) tracker.check_result(rsp_if.data);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (rsp_calm) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= 31);
      end
    end
  end

  function automatic fba_pkg::req_t make_req(logic kind, logic [fba_pkg::SLOT_W-1:0] slot,
                                             logic [fba_pkg::VAL_W-1:0] val);
    fba_pkg::req_t r;
    r.req_type = kind;
    r.block_slot = slot;
    r.size_value = val;
    return r;
  endfunction

  // Offer one item, with random idle cycles first, and wait until it is taken.
  // Valid stays high afterwards so back-to-back items need no extra cycle.
  task automatic push_request(input fba_pkg::req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data <= r;
    do @(posedge clk_i); while (!req_if.ready);
    tracker.note_request(r);
  endtask

  // Stop offering and wait for every outstanding result, then let the block settle.
  task automatic wait_drained(input int unsigned settle);
    req_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic program_reg(input logic [fba_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fba_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_reg(idx, val);
    settings_seen++;
  endtask

  // Random mode values also carry random upper bits, which the block ignores.
  task automatic program_fit(input logic [1:0] mode, input logic [4:0] count);
    program_reg(fba_pkg::REG_FIT_MODE, {3'($urandom), mode});
    program_reg(fba_pkg::REG_BLOCKS_IN_USE, count);
  endtask

  function automatic fba_pkg::req_t random_request();
    logic [fba_pkg::VAL_W-1:0] val;
    int unsigned               pick;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 25) begin
      val = (pick < 10) ? 16'($urandom) : 16'($urandom_range(0, 4000));
      return make_req(fba_pkg::REQ_LOAD, 4'($urandom_range(BLOCKS - 1)), val);
    end
    if (pick < 8) val = '0;
    else if (pick < 18) val = 16'($urandom);
    else val = 16'($urandom_range(1, 1200));
    return make_req(fba_pkg::REQ_ALLOC, 4'($urandom), val);
  endfunction

  // Main stimulus: directed corner cases, then randomized phases.
  initial begin : stim
    logic [1:0] mode;
    logic [4:0] count;
    logic [fba_pkg::VAL_W-1:0] val;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_wdata_i <= '0;
    req_if.valid <= 1'b0;
    req_if.data <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table at reset: a zero request still fits, anything larger is refused.
    push_request(make_req(fba_pkg::REQ_ALLOC, 4'd9, 16'd0));
    push_request(make_req(fba_pkg::REQ_ALLOC, 4'd0, 16'd1));
    push_request(make_req(fba_pkg::REQ_LOAD, 4'd0, 16'd100));
    push_request(make_req(fba_pkg::REQ_LOAD, 4'd3, 16'd40));
    push_request(make_req(fba_pkg::REQ_LOAD, 4'd7, 16'd60));
    push_request(make_req(fba_pkg::REQ_LOAD, 4'd15, 16'hFFFF));
    push_request(make_req(fba_pkg::REQ_LOAD, 4'd9, 16'd0));
    push_request(make_req(fba_pkg::REQ_ALLOC, 4'd0, 16'd50));
    push_request(make_req(fba_pkg::REQ_ALLOC, 4'd15, 16'hFFFF));
    push_request(make_req(fba_pkg::REQ_ALLOC, 4'd0, 16'hFFFF));

    // Best fit, then worst fit with a tie between two equal blocks.
    wait_drained(SETTLE_CYCLES);
    program_reg(fba_pkg::REG_FIT_MODE, {3'b000, fba_pkg::FIT_BEST});
    push_request(make_req(fba_pkg::REQ_ALLOC, 4'd0, 16'd45));
    push_request(make_req(fba_pkg::REQ_ALLOC, 4'd0, 16'd5));
    wait_drained(SETTLE_CYCLES);
    program_reg(fba_pkg::REG_FIT_MODE, {3'b000, fba_pkg::FIT_WORST});
    push_request(make_req(fba_pkg::REQ_LOAD, 4'd5, 16'd60));
    push_request(make_req(fba_pkg::REQ_ALLOC, 4'd0, 16'd10));

    // The unused mode code behaves as first fit.
    wait_drained(SETTLE_CYCLES);
    program_reg(fba_pkg::REG_FIT_MODE, {3'b111, FIT_UNUSED});
    push_request(make_req(fba_pkg::REQ_ALLOC, 4'd0, 16'd20));

    // No blocks in use: every allocation is refused.
    wait_drained(SETTLE_CYCLES);
    program_reg(fba_pkg::REG_BLOCKS_IN_USE, 5'd0);
    push_request(make_req(fba_pkg::REQ_ALLOC, 4'd0, 16'd0));

    // A load beyond the searched range is stored but not found until the range grows.
    wait_drained(SETTLE_CYCLES);
    program_reg(fba_pkg::REG_BLOCKS_IN_USE, 5'd2);
    push_request(make_req(fba_pkg::REQ_LOAD, 4'd12, 16'd500));
    push_request(make_req(fba_pkg::REQ_ALLOC, 4'd0, 16'd400));
    wait_drained(SETTLE_CYCLES);
    program_fit(fba_pkg::FIT_BEST, 5'd31);
    push_request(make_req(fba_pkg::REQ_ALLOC, 4'd0, 16'd400));

    // Random phases: each restarts by reloading every block, then mixes requests.
    for (int p = 0; p < 9; p++) begin
      wait_drained(SETTLE_CYCLES);
      case (p)
        0: begin mode = fba_pkg::FIT_FIRST; count = 5'd16; end
        1: begin mode = fba_pkg::FIT_BEST;  count = 5'd16; end
        2: begin mode = fba_pkg::FIT_WORST; count = 5'd16; end
        3: begin mode = FIT_UNUSED; count = 5'd1; end
        default: begin
          mode = 2'($urandom_range(3));
          count = 5'($urandom_range(1, 31));
        end
      endcase
      program_fit(mode, count);
      if (p == 2) begin
        send_idle_pct = 0;
        rsp_calm = 1'b1;
      end
      for (int s = 0; s < BLOCKS; s++) begin
        val = ($urandom_range(99) < 10) ? 16'($urandom) : 16'($urandom_range(200, 4000));
        push_request(make_req(fba_pkg::REQ_LOAD, 4'(s), val));
      end
      for (int k = 0; k < 40; k++) begin
        // Stall the result side while requests keep coming, so the block backs up.
        if (p == 4 && k == 5) hold_req = 1'b1;
        // Let the block drain completely in the middle of a phase.
        if (p == 6 && k == 20) wait_drained(0);
        push_request(random_request());
      end
      send_idle_pct = 31;
      rsp_calm = 1'b0;
    end

    wait_drained(SETTLE_CYCLES);
    $display("Run covered %0d loads and %0d allocations (%0d granted, %0d refused).",
             tracker.loads, tracker.grants + tracker.refusals, tracker.grants,
             tracker.refusals);
    $display("Register writes: %0d, across all fit modes and block counts 0 to 31; %0d faults.",
             settings_seen, tracker.faults);
    if (tracker.faults == 0 && tracker.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #1_000_000;
    $display("Timeout with %0d results still outstanding.", tracker.pending());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
